// ----- design/pp2r_pkg.sv -----
package pp2r_pkg;

  localparam int MAX_HEIGHT  = 4096;
  localparam int CFG_INDEX_W = 3;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 31;
  localparam int DIV_LANES   = 3;
  localparam int NUM_W       = 77;

  localparam logic [CFG_INDEX_W-1:0] REG_KINV_00 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KINV_01 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KINV_02 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KINV_10 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KINV_11 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KINV_12 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT  = 3'd6;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_column;
  } pix_in_t;

  typedef struct packed {
    logic signed [31:0] plane_x;
    logic signed [31:0] plane_y;
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
    logic [30:0]        ray_z;
  } ray_out_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [3:0]         shift;
  } sqrt_side_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
  } div_side_t;

endpackage

// ----- design/pinhole_pixel_to_unit_ray.sv -----
// Pixel to unit ray back-projection for a pinhole camera.
// Input channel: in_valid / in_stall / in_data carries one pixel request
// (row, column). Output channel: out_valid / out_stall / out_data carries
// the plane point (Q16.16, saturated) and the unit ray (Q2.30).
// Configuration: write the inverse intrinsics rows and the image height
// through cfg_wen / cfg_index / cfg_data while no request is in flight.
// The pipeline takes one request per cycle while out_stall does not hold
// it: 7 stages of flip, multiply, round and normalize, 32 stages of square
// root (one root bit each), one numerator stage, 31 stages of three-lane
// division (one quotient bit each) and the output register.
// When out_valid is high and out_stall is set, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity inverse matrix and a
// height of one.
module pinhole_pixel_to_unit_ray import pp2r_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pix_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ray_out_t               out_data
);

  function automatic logic signed [31:0] round_sat(input logic signed [48:0] v);
    logic signed [48:0] r;
    r = (v + 49'sd2048) >>> 12;
    if (r > 49'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (r < -49'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return r[31:0];
    end
  endfunction

  logic signed [31:0] kinv [6];
  logic [12:0]        height;

  always_ff @(posedge clk) begin
    if (rst) begin
      kinv[0] <= 32'sh10000000;
      kinv[1] <= '0;
      kinv[2] <= '0;
      kinv[3] <= '0;
      kinv[4] <= 32'sh10000000;
      kinv[5] <= '0;
      height  <= 13'd1;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_KINV_00: kinv[0] <= cfg_data;
        REG_KINV_01: kinv[1] <= cfg_data;
        REG_KINV_02: kinv[2] <= cfg_data;
        REG_KINV_10: kinv[3] <= cfg_data;
        REG_KINV_11: kinv[4] <= cfg_data;
        REG_KINV_12: kinv[5] <= cfg_data;
        REG_HEIGHT:  height  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // flip
  logic [12:0]        h_eff;
  logic signed [13:0] fy_next;
  logic               v1;
  logic signed [13:0] fy1;
  logic [11:0]        col1;

  always_comb begin
    if (height == 13'd0) begin
      h_eff = 13'd1;
    end else if (height > 13'(MAX_HEIGHT)) begin
      h_eff = 13'(MAX_HEIGHT);
    end else begin
      h_eff = height;
    end
    fy_next = $signed({1'b0, h_eff}) - 14'sd1 - $signed({2'b00, in_data.pixel_row});
  end

  // multiply
  logic               v2;
  logic signed [45:0] colx;
  logic signed [45:0] fyx;
  logic signed [45:0] p00, p01, p10, p11;
  assign colx = 46'($signed({1'b0, col1}));
  assign fyx  = 46'(fy1);

  // round and saturate
  logic               v3;
  logic signed [31:0] px3, py3;

  // squares
  logic               v4;
  logic [31:0]        ax, ay;
  logic [63:0]        sqx, sqy;
  sqrt_side_t         sd4;
  assign ax = px3[31] ? 32'(-px3) : px3;
  assign ay = py3[31] ? 32'(-py3) : py3;

  // norm square and normalize
  logic               v5, v6, v7;
  logic [63:0]        nsq5, n6, n7;
  sqrt_side_t         sd5, sd6, sd7;
  logic [63:0]        n6_next, n7_next;
  logic [3:0]         s6_next, s7_next;
  logic [63:0]        n6_mid, n7_mid;
  logic [3:0]         s6_mid, s7_mid;

  always_comb begin
    n6_mid = (nsq5[63:48] == '0) ? {nsq5[47:0], 16'h0} : nsq5;
    s6_mid = (nsq5[63:48] == '0) ? 4'd8 : 4'd0;
    n6_next = (n6_mid[63:56] == '0) ? {n6_mid[55:0], 8'h0} : n6_mid;
    s6_next = (n6_mid[63:56] == '0) ? s6_mid + 4'd4 : s6_mid;
    n7_mid = (n6[63:60] == '0) ? {n6[59:0], 4'h0} : n6;
    s7_mid = (n6[63:60] == '0) ? sd6.shift + 4'd2 : sd6.shift;
    n7_next = (n7_mid[63:62] == '0) ? {n7_mid[61:0], 2'b00} : n7_mid;
    s7_next = (n7_mid[63:62] == '0) ? s7_mid + 4'd1 : s7_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
    if (en) begin
      fy1  <= fy_next;
      col1 <= in_data.pixel_column;
      p00  <= 46'(kinv[0]) * colx;
      p01  <= 46'(kinv[1]) * fyx;
      p10  <= 46'(kinv[3]) * colx;
      p11  <= 46'(kinv[4]) * fyx;
      px3  <= round_sat(49'(p00) + 49'(p01) + 49'(kinv[2]));
      py3  <= round_sat(49'(p10) + 49'(p11) + 49'(kinv[5]));
      sqx  <= 64'(ax) * 64'(ax);
      sqy  <= 64'(ay) * 64'(ay);
      sd4  <= '{px: px3, py: py3, shift: 4'd0};
      nsq5 <= sqx + sqy + 64'h1_0000_0000;
      sd5  <= sd4;
      n6   <= n6_next;
      sd6  <= '{px: sd5.px, py: sd5.py, shift: s6_next};
      n7   <= n7_next;
      sd7  <= '{px: sd6.px, py: sd6.py, shift: s7_next};
    end
  end

  // square root
  logic        sq_valid;
  logic [31:0] sq_root;
  sqrt_side_t  sq_side;

  pp2r_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .x         (n7),
    .in_side   (sd7),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // numerators
  logic [31:0]      mag [DIV_LANES];
  logic [5:0]       sh;
  logic             vn;
  logic [NUM_W-1:0] num [DIV_LANES];
  logic [31:0]      den;
  div_side_t        dside;

  assign mag[0] = sq_side.px[31] ? 32'(-sq_side.px) : sq_side.px;
  assign mag[1] = sq_side.py[31] ? 32'(-sq_side.py) : sq_side.py;
  assign mag[2] = 32'h0001_0000;
  assign sh     = 6'd30 + 6'(sq_side.shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= sq_valid;
    end
    if (en) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        num[l] <= (NUM_W'(mag[l]) << sh) + NUM_W'(sq_root[31:1]);
      end
      den   <= sq_root;
      dside <= '{px: sq_side.px, py: sq_side.py};
    end
  end

  // divide
  logic        dv_valid;
  logic [30:0] quot [DIV_LANES];
  div_side_t   dv_side;

  pp2r_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vn),
    .num       (num),
    .den       (den),
    .in_side   (dside),
    .out_valid (dv_valid),
    .quot      (quot),
    .out_side  (dv_side)
  );

  // output register
  ray_out_t out_data_next;
  always_comb begin
    out_data_next.plane_x = dv_side.px;
    out_data_next.plane_y = dv_side.py;
    out_data_next.ray_x   = dv_side.px[31] ? -$signed({1'b0, quot[0]}) : $signed({1'b0, quot[0]});
    out_data_next.ray_y   = dv_side.py[31] ? -$signed({1'b0, quot[1]}) : $signed({1'b0, quot[1]});
    out_data_next.ray_z   = quot[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
    if (en) begin
      out_data <= out_data_next;
    end
  end

  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    v7 |-> n7[63:62] != 2'b00)
    else $error("normalized norm square below range");

  a_root_msb: assert property (@(posedge clk) disable iff (rst)
    sq_valid |-> sq_root[31])
    else $error("square root below 2^31");

  a_ray_z: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.ray_z != 31'd0 && out_data.ray_z <= 31'h4000_0000))
    else $error("ray z out of range");

endmodule

// ----- design/pp2r_sqrt.sv -----
module pp2r_sqrt import pp2r_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] x,
  input  sqrt_side_t  in_side,
  output logic        out_valid,
  output logic [31:0] root,
  output sqrt_side_t  out_side
);

  logic        vld [1:SQRT_STEPS];
  logic [33:0] rem [1:SQRT_STEPS];
  logic [31:0] rt  [1:SQRT_STEPS];
  logic [63:0] xs  [1:SQRT_STEPS];
  sqrt_side_t  sd  [1:SQRT_STEPS];

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
    logic        pv;
    logic [33:0] prem;
    logic [31:0] prt;
    logic [63:0] pxs;
    sqrt_side_t  psd;
    logic [35:0] cat;
    logic [35:0] trial;

    if (k == 1) begin : g_first
      assign pv   = in_valid;
      assign prem = '0;
      assign prt  = '0;
      assign pxs  = x;
      assign psd  = in_side;
    end else begin : g_rest
      assign pv   = vld[k-1];
      assign prem = rem[k-1];
      assign prt  = rt[k-1];
      assign pxs  = xs[k-1];
      assign psd  = sd[k-1];
    end

    assign cat   = {prem, pxs[63:62]};
    assign trial = {2'b00, prt, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
      if (en) begin
        xs[k] <= {pxs[61:0], 2'b00};
        sd[k] <= psd;
        if (cat >= trial) begin
          rem[k] <= 34'(cat - trial);
          rt[k]  <= {prt[30:0], 1'b1};
        end else begin
          rem[k] <= cat[33:0];
          rt[k]  <= {prt[30:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS];
  assign root      = rt[SQRT_STEPS];
  assign out_side  = sd[SQRT_STEPS];

endmodule

// ----- design/pp2r_div.sv -----
module pp2r_div import pp2r_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num [DIV_LANES],
  input  logic [31:0]      den,
  input  div_side_t        in_side,
  output logic             out_valid,
  output logic [30:0]      quot [DIV_LANES],
  output div_side_t        out_side
);

  logic        vld [1:DIV_STEPS];
  logic [31:0] dv  [1:DIV_STEPS];
  div_side_t   sd  [1:DIV_STEPS];
  logic [31:0] rem [1:DIV_STEPS][DIV_LANES];
  logic [30:0] lo  [1:DIV_STEPS][DIV_LANES];
  logic [30:0] q   [1:DIV_STEPS][DIV_LANES];

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic        pv;
    logic [31:0] pdv;
    div_side_t   psd;
    logic [31:0] prem [DIV_LANES];
    logic [30:0] plo  [DIV_LANES];
    logic [30:0] pq   [DIV_LANES];

    if (k == 1) begin : g_first
      assign pv  = in_valid;
      assign pdv = den;
      assign psd = in_side;
      for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
        assign prem[l] = num[l][62:31];
        assign plo[l]  = num[l][30:0];
        assign pq[l]   = '0;
      end
    end else begin : g_rest
      assign pv  = vld[k-1];
      assign pdv = dv[k-1];
      assign psd = sd[k-1];
      for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
        assign prem[l] = rem[k-1][l];
        assign plo[l]  = lo[k-1][l];
        assign pq[l]   = q[k-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
      if (en) begin
        dv[k] <= pdv;
        sd[k] <= psd;
        for (int l = 0; l < DIV_LANES; l++) begin
          lo[k][l] <= {plo[l][29:0], 1'b0};
          if ({prem[l], plo[l][30]} >= {1'b0, pdv}) begin
            rem[k][l] <= 32'({prem[l], plo[l][30]} - {1'b0, pdv});
            q[k][l]   <= {pq[l][29:0], 1'b1};
          end else begin
            rem[k][l] <= {prem[l][30:0], plo[l][30]};
            q[k][l]   <= {pq[l][29:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign out_side  = sd[DIV_STEPS];
  for (genvar l = 0; l < DIV_LANES; l++) begin : g_out
    assign quot[l] = q[DIV_STEPS][l];
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import pp2r_pkg::*;

  localparam int  FLUSH_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 600000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_KINV_00;
  logic [31:0] cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pix_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ray_out_t out_data;

  logic signed [31:0] kinv [0:5];
  logic [12:0] height;

  ray_out_t expected_rays[$];
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  int  mismatches = 0;
  int  pixels_sent = 0;
  int  rays_checked = 0;
  int  cameras_loaded = 0;
  longint cycles = 0;

  pinhole_pixel_to_unit_ray u_dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  function automatic longint round_q16(longint v);
    longint r;
    r = (v + 2048) >>> 12;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic longint unit_part(longint v, int s, bit [63:0] n);
    bit [63:0] mag, q;
    mag = (v < 0) ? -v : v;
    q = ((mag << (30 + s)) + (n >> 1)) / n;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic ray_out_t project_pixel(pix_in_t p);
    longint hh, fy, px, py;
    bit [63:0] ax, ay, nsq, rem, root, b;
    int s;
    ray_out_t r;
    hh = longint'(height);
    if (hh < 1) hh = 1;
    if (hh > MAX_HEIGHT) hh = MAX_HEIGHT;
    fy = hh - 1 - longint'(p.pixel_row);
    px = round_q16(longint'(kinv[0]) * longint'(p.pixel_column) + longint'(kinv[1]) * fy
                   + longint'(kinv[2]));
    py = round_q16(longint'(kinv[3]) * longint'(p.pixel_column) + longint'(kinv[4]) * fy
                   + longint'(kinv[5]));
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    nsq = ax * ax + ay * ay + (64'd1 << 32);
    s = 0;
    while (nsq < (64'd1 << 62)) begin
      nsq = nsq << 2;
      s++;
    end
    rem = nsq;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    r.plane_x = px[31:0];
    r.plane_y = py[31:0];
    r.ray_x = 32'(unit_part(px, s, root));
    r.ray_y = 32'(unit_part(py, s, root));
    r.ray_z = 31'(unit_part(64'sd65536, s, root));
    return r;
  endfunction

  always @(posedge clk) begin
    ray_out_t want;
    if (!rst && out_valid && !out_stall) begin
      rays_checked++;
      if (expected_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected ray %h", out_data);
      end else begin
        want = expected_rays.pop_front();
        if (out_data.plane_x !== want.plane_x || out_data.plane_y !== want.plane_y ||
            out_data.ray_x !== want.ray_x || out_data.ray_y !== want.ray_y ||
            out_data.ray_z !== want.ray_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ray %0d: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                     rays_checked, want.plane_x, want.plane_y, want.ray_x, want.ray_y,
                     want.ray_z, out_data.plane_x, out_data.plane_y, out_data.ray_x,
                     out_data.ray_y, out_data.ray_z);
        end
      end
    end
  end

  task automatic send_pixel(logic [11:0] row, logic [11:0] col);
    pix_in_t p;
    p.pixel_row = row;
    p.pixel_column = col;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    expected_rays.push_back(project_pixel(p));
    pixels_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_rays.size() > 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic load_camera(logic [31:0] k00, logic [31:0] k01, logic [31:0] k02,
                             logic [31:0] k10, logic [31:0] k11, logic [31:0] k12,
                             logic [12:0] h);
    logic [31:0] vals [0:6];
    logic [CFG_INDEX_W-1:0] idx [0:6];
    drain();
    vals = '{k00, k01, k02, k10, k11, k12, {19'd0, h}};
    idx = '{REG_KINV_00, REG_KINV_01, REG_KINV_02, REG_KINV_10, REG_KINV_11,
            REG_KINV_12, REG_HEIGHT};
    for (int i = 0; i < 7; i++) begin
      cfg_wen <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    kinv = '{k00, k01, k02, k10, k11, k12};
    height = h;
    cameras_loaded++;
  endtask

  task automatic load_random_camera;
    if ($urandom_range(1))
      load_camera($urandom_range(32'h0200_0000, 32'h0008_0000), $urandom_range(32'h4000) - 32'h2000,
                  -$urandom_range(32'h1000_0000), $urandom_range(32'h4000) - 32'h2000,
                  $urandom_range(32'h0200_0000, 32'h0008_0000), -$urandom_range(32'h1000_0000),
                  13'($urandom_range(4096, 1)));
    else
      load_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 13'($urandom));
  endtask

  task automatic test_corners;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    load_camera(32'h0008_0000, 32'd0, 32'hF000_0000, 32'd0, 32'h0008_0000, 32'hF800_0000,
                13'd480);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd479, 12'd639);
    send_pixel(12'd480, 12'd640);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd240, 12'd320);
  endtask

  task automatic test_height_limits;
    load_camera(32'h1000_0000, 32'h0000_1000, 32'd0, 32'hFFFF_F000, 32'h1000_0000, 32'd0,
                13'd0);
    send_pixel(12'd0, 12'd7);
    send_pixel(12'd4095, 12'd7);
    load_camera(32'h1000_0000, 32'd0, 32'd0, 32'd0, 32'h1000_0000, 32'd0, 13'h1FFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd1);
    load_camera(32'h1000_0000, 32'd0, 32'd0, 32'd0, 32'h1000_0000, 32'd0, 13'd4096);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd2048);
  endtask

  task automatic test_saturation;
    load_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 13'd4096);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    load_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 13'd1);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
  endtask

  task automatic test_random(int in_pct, int out_pct, int count);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 149) load_random_camera();
      if (i == count / 2) drain();
      if ($urandom_range(3) == 0)
        send_pixel(12'($urandom), 12'($urandom));
      else
        send_pixel(12'($urandom_range(height > 1 ? height - 1 : 0)),
                   12'($urandom_range(1023)));
    end
  endtask

  initial begin
    kinv = '{32'h1000_0000, 32'd0, 32'd0, 32'd0, 32'h1000_0000, 32'd0};
    height = 13'd1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_height_limits();
    test_saturation();
    load_random_camera();
    test_random(24, 79, 600);
    test_random(79, 24, 600);
    test_random(0, 0, 620);
    drain();
    $display("checked %0d rays from %0d pixels across %0d camera settings",
             rays_checked, pixels_sent, cameras_loaded);
    $display("including height clamping, row flips below zero and plane saturation");
    if (mismatches == 0 && expected_rays.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d rays missing", mismatches, expected_rays.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
